// ----- rtl/core/pdbs_pkg.sv -----
// Package for the particle drag/bounce step unit: field widths, register
// indexes, reset values and the payload struct. No dependencies.
package pdbs_pkg;

    localparam int POS_W   = 18;
    localparam int VEL_W   = 19;
    localparam int CUR_W   = 10;
    localparam int DT_W    = 13;
    localparam int RAD_W   = 8;
    localparam int DAMP_W  = 12;
    localparam int CFG_W   = 19;
    localparam int IDX_W   = 3;
    localparam int TDATA_W = 80;

    localparam int MAG_W   = 18;   // |cursor - position| per axis
    localparam int SQ_W    = 38;   // dx^2 + dy^2
    localparam int ROOT_W  = 19;   // floor square root
    localparam int RR_W    = 16;   // radius in 1/256 px
    localparam int INFL_W  = 16;   // influence fraction bits, value is Q1.16
    localparam int KDT_W   = 30;
    localparam int K_W     = 33;
    localparam int DIFF_W  = 20;
    localparam int ACC_W   = 53;
    localparam int VD_W    = 24;   // velocity after drag, signed
    localparam int PW_W    = 25;   // position before clamp, signed
    localparam int FAC_W   = 25;   // damping factor, Q1.24

    localparam int DEF_FIELD_WIDTH  = 900;
    localparam int DEF_FIELD_HEIGHT = 600;
    localparam int POS_FIELD_MAX    = 262143;
    localparam int VEL_LIMIT        = 256000;

    localparam logic [RAD_W-1:0]  RADIUS_RESET  = 8'd50;
    localparam logic [DAMP_W-1:0] DAMPING_RESET = 12'd128;

    typedef enum logic [IDX_W-1:0] {
        REG_CURSOR_X     = 3'd0,
        REG_CURSOR_Y     = 3'd1,
        REG_CURSOR_VEL_X = 3'd2,
        REG_CURSOR_VEL_Y = 3'd3,
        REG_DRAG_ENABLE  = 3'd4,
        REG_TIME_STEP    = 3'd5,
        REG_RADIUS       = 3'd6,
        REG_DAMPING      = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [POS_W-1:0]        px;
        logic [POS_W-1:0]        py;
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
    } particle_t;

endpackage

// ----- rtl/core/particle_drag_bounce_step_unit.sv -----
// Top level of the particle drag/bounce step unit: one particle per word.
// Depends on pdbs_pkg.
//
// Usage: particles enter on the s_axis channel (tdata fields from bit 0:
// pos_x, pos_y, vel_x, vel_y) and leave on m_axis in the same packing as
// new_pos_x, new_pos_y, new_vel_x, new_vel_y, one result per particle, in
// order. Software writes the eight registers over cfg_we/cfg_index/cfg_data
// while no particle is in flight.
// The pipeline has 48 register stages. Throughput is one particle per cycle
// while the receiver does not stall: the distance square root takes one root
// bit per stage (19 stages) and the influence divide one quotient bit per
// stage (16 stages), with the multiplies spread over registered stages behind
// them. The damping factor is registered from the damping and time-step
// registers. Reset clears all valid bits and loads the register reset values.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready falls; nothing is dropped or repeated.
module particle_drag_bounce_step_unit #(
    parameter int FIELD_WIDTH  = pdbs_pkg::DEF_FIELD_WIDTH,
    parameter int FIELD_HEIGHT = pdbs_pkg::DEF_FIELD_HEIGHT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [pdbs_pkg::IDX_W-1:0]    cfg_index,
    input  logic [pdbs_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x[17:0], pos_y[35:18], vel_x[54:36], vel_y[73:55], zero fill
    input  logic [pdbs_pkg::TDATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // new_pos_x[17:0], new_pos_y[35:18], new_vel_x[54:36], new_vel_y[73:55]
    output logic [pdbs_pkg::TDATA_W-1:0]  m_tdata
);
    import pdbs_pkg::*;

    localparam int EDGE_X_I = ((FIELD_WIDTH - 1) * 256 > POS_FIELD_MAX) ?
                              POS_FIELD_MAX : (FIELD_WIDTH - 1) * 256;
    localparam int EDGE_Y_I = ((FIELD_HEIGHT - 1) * 256 > POS_FIELD_MAX) ?
                              POS_FIELD_MAX : (FIELD_HEIGHT - 1) * 256;
    localparam logic signed [PW_W-1:0] EDGE_X = PW_W'(EDGE_X_I);
    localparam logic signed [PW_W-1:0] EDGE_Y = PW_W'(EDGE_Y_I);
    localparam logic [VD_W:0] VLIM = (VD_W+1)'(VEL_LIMIT);

    // ---------------- configuration registers ----------------
    logic [CUR_W-1:0]        cur_x_reg, cur_y_reg;
    logic signed [VEL_W-1:0] cvx_reg, cvy_reg;
    logic                    drag_en_reg;
    logic [DT_W-1:0]         dt_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [DAMP_W-1:0]       damp_reg;
    logic [FAC_W-1:0]        fac_reg;
    logic [FAC_W-1:0]        fac_next;
    logic [DAMP_W+DT_W-1:0]  damp_dt;

    // Decode register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg   <= '0;
            cur_y_reg   <= '0;
            cvx_reg     <= '0;
            cvy_reg     <= '0;
            drag_en_reg <= 1'b0;
            dt_reg      <= '0;
            rad_reg     <= RADIUS_RESET;
            damp_reg    <= DAMPING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_CURSOR_X:     cur_x_reg   <= cfg_data[CUR_W-1:0];
                REG_CURSOR_Y:     cur_y_reg   <= cfg_data[CUR_W-1:0];
                REG_CURSOR_VEL_X: cvx_reg     <= $signed(cfg_data[VEL_W-1:0]);
                REG_CURSOR_VEL_Y: cvy_reg     <= $signed(cfg_data[VEL_W-1:0]);
                REG_DRAG_ENABLE:  drag_en_reg <= cfg_data[0];
                REG_TIME_STEP:    dt_reg      <= cfg_data[DT_W-1:0];
                REG_RADIUS:       rad_reg     <= cfg_data[RAD_W-1:0];
                REG_DAMPING:      damp_reg    <= cfg_data[DAMP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Form the damping factor 2^24 - damping*dt, floored at zero
    always_comb
    begin
        damp_dt = damp_reg * dt_reg;
        if (damp_dt > (DAMP_W+DT_W)'(1 << 24))
            fac_next = '0;
        else
            fac_next = FAC_W'(1 << 24) - FAC_W'(damp_dt);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fac_reg <= '0;
        else
            fac_reg <= fac_next;
    end

    // ---------------- pipeline control ----------------
    logic adv;
    logic l_vld_reg;
    assign adv      = !l_vld_reg || m_tready;
    assign s_tready = adv;

    // ---------------- stage A: capture, cursor distances ----------------
    particle_t        in_p;
    logic signed [POS_W:0] dx_s, dy_s;
    logic             a_vld_reg;
    particle_t        a_p_reg;
    logic [MAG_W-1:0] a_ax_reg, a_ay_reg;

    always_comb
    begin
        in_p.px = s_tdata[POS_W-1:0];
        in_p.py = s_tdata[2*POS_W-1:POS_W];
        in_p.vx = $signed(s_tdata[2*POS_W+VEL_W-1:2*POS_W]);
        in_p.vy = $signed(s_tdata[2*POS_W+2*VEL_W-1:2*POS_W+VEL_W]);
        dx_s = $signed({1'b0, cur_x_reg, 8'b0}) - $signed({1'b0, in_p.px});
        dy_s = $signed({1'b0, cur_y_reg, 8'b0}) - $signed({1'b0, in_p.py});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else if (adv)
            a_vld_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_p_reg  <= in_p;
            a_ax_reg <= dx_s[POS_W] ? MAG_W'(-dx_s) : MAG_W'(dx_s);
            a_ay_reg <= dy_s[POS_W] ? MAG_W'(-dy_s) : MAG_W'(dy_s);
        end
    end

    // ---------------- stage B: squares ----------------
    logic               b_vld_reg;
    particle_t          b_p_reg;
    logic [2*MAG_W-1:0] b_sx_reg, b_sy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else if (adv)
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_p_reg  <= a_p_reg;
            b_sx_reg <= a_ax_reg * a_ax_reg;
            b_sy_reg <= a_ay_reg * a_ay_reg;
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic              sq_vld_reg [ROOT_W+1];
    particle_t         sq_p_reg   [ROOT_W+1];
    logic [SQ_W-1:0]   sq_n_reg   [ROOT_W+1];
    logic [ROOT_W-1:0] sq_q_reg   [ROOT_W+1];

    // Sum the squares into the root input
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_vld_reg[0] <= 1'b0;
        else if (adv)
            sq_vld_reg[0] <= b_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_p_reg[0] <= b_p_reg;
            sq_n_reg[0] <= SQ_W'(b_sx_reg) + SQ_W'(b_sy_reg);
            sq_q_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_sqrt
        localparam int SH = 2 * (ROOT_W - 1 - j);
        logic [SQ_W-1:0] trial;
        assign trial = SQ_W'({sq_q_reg[j], 2'b01}) << SH;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_vld_reg[j+1] <= 1'b0;
            else if (adv)
                sq_vld_reg[j+1] <= sq_vld_reg[j];
        end

        // Try the next root bit, keep it when the remainder allows
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_p_reg[j+1] <= sq_p_reg[j];
                if (sq_n_reg[j] >= trial)
                begin
                    sq_n_reg[j+1] <= sq_n_reg[j] - trial;
                    sq_q_reg[j+1] <= {sq_q_reg[j][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    sq_n_reg[j+1] <= sq_n_reg[j];
                    sq_q_reg[j+1] <= {sq_q_reg[j][ROOT_W-2:0], 1'b0};
                end
            end
        end
    end

    // ---------------- influence divide, one quotient bit per stage ----------
    logic [RR_W-1:0]   rr;
    logic              hit;
    logic              d_zero;
    logic              dv_vld_reg [INFL_W+1];
    particle_t         dv_p_reg   [INFL_W+1];
    logic [RR_W:0]     dv_rem_reg [INFL_W+1];
    logic [INFL_W:0]   dv_q_reg   [INFL_W+1];

    assign rr     = {rad_reg, 8'b0};
    assign hit    = drag_en_reg && (ROOT_W'(rr) > sq_q_reg[ROOT_W]);
    assign d_zero = (sq_q_reg[ROOT_W] == '0);

    // Start with R - d inside the radius with drag enabled, zero otherwise (no
    // drag); a particle on the cursor gets full influence from the integer bit alone
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (adv)
            dv_vld_reg[0] <= sq_vld_reg[ROOT_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_p_reg[0]   <= sq_p_reg[ROOT_W];
            dv_rem_reg[0] <= (hit && !d_zero) ?
                             (RR_W+1)'(rr - RR_W'(sq_q_reg[ROOT_W])) : '0;
            dv_q_reg[0]   <= {{INFL_W{1'b0}}, hit && d_zero};
        end
    end

    for (genvar j = 0; j < INFL_W; j++)
    begin : g_div
        logic [RR_W:0] dbl;
        assign dbl = {dv_rem_reg[j][RR_W-1:0], 1'b0};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_vld_reg[j+1] <= 1'b0;
            else if (adv)
                dv_vld_reg[j+1] <= dv_vld_reg[j];
        end

        // Shift the remainder, subtract R when it fits
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_p_reg[j+1] <= dv_p_reg[j];
                if (rr != '0 && dbl >= {1'b0, rr})
                begin
                    dv_rem_reg[j+1] <= dbl - {1'b0, rr};
                    dv_q_reg[j+1]   <= {dv_q_reg[j][INFL_W-1:0], 1'b1};
                end
                else
                begin
                    dv_rem_reg[j+1] <= dbl;
                    dv_q_reg[j+1]   <= {dv_q_reg[j][INFL_W-1:0], 1'b0};
                end
            end
        end
    end

    // ---------------- stage D: influence * dt ----------------
    logic             d_vld_reg;
    particle_t        d_p_reg;
    logic [KDT_W-1:0] d_kdt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_vld_reg <= 1'b0;
        else if (adv)
            d_vld_reg <= dv_vld_reg[INFL_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_p_reg   <= dv_p_reg[INFL_W];
            d_kdt_reg <= dv_q_reg[INFL_W] * dt_reg;
        end
    end

    // ---------------- stage E: gain * 10, velocity gap ----------------
    logic signed [DIFF_W-1:0] gx, gy;
    logic              e_vld_reg;
    particle_t         e_p_reg;
    logic [K_W-1:0]    e_k_reg;
    logic [DIFF_W-1:0] e_mx_reg, e_my_reg;
    logic              e_nx_reg, e_ny_reg;

    assign gx = DIFF_W'(cvx_reg) - DIFF_W'(d_p_reg.vx);
    assign gy = DIFF_W'(cvy_reg) - DIFF_W'(d_p_reg.vy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_vld_reg <= 1'b0;
        else if (adv)
            e_vld_reg <= d_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e_p_reg  <= d_p_reg;
            e_k_reg  <= (K_W'(d_kdt_reg) << 3) + (K_W'(d_kdt_reg) << 1);
            e_nx_reg <= gx[DIFF_W-1];
            e_ny_reg <= gy[DIFF_W-1];
            e_mx_reg <= gx[DIFF_W-1] ? DIFF_W'(-gx) : DIFF_W'(gx);
            e_my_reg <= gy[DIFF_W-1] ? DIFF_W'(-gy) : DIFF_W'(gy);
        end
    end

    // ---------------- stage F: partial products ----------------
    logic                  f_vld_reg;
    particle_t             f_p_reg;
    logic                  f_nx_reg, f_ny_reg;
    logic [DIFF_W+15:0]    f_xl_reg, f_yl_reg;
    logic [DIFF_W+K_W-17:0] f_xh_reg, f_yh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_vld_reg <= 1'b0;
        else if (adv)
            f_vld_reg <= e_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_p_reg  <= e_p_reg;
            f_nx_reg <= e_nx_reg;
            f_ny_reg <= e_ny_reg;
            f_xl_reg <= e_mx_reg * e_k_reg[15:0];
            f_yl_reg <= e_my_reg * e_k_reg[15:0];
            f_xh_reg <= e_mx_reg * e_k_reg[K_W-1:16];
            f_yh_reg <= e_my_reg * e_k_reg[K_W-1:16];
        end
    end

    // ---------------- stage G: sum partials ----------------
    logic             g_vld_reg;
    particle_t        g_p_reg;
    logic             g_nx_reg, g_ny_reg;
    logic [ACC_W-1:0] g_ax_reg, g_ay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_vld_reg <= 1'b0;
        else if (adv)
            g_vld_reg <= f_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            g_p_reg  <= f_p_reg;
            g_nx_reg <= f_nx_reg;
            g_ny_reg <= f_ny_reg;
            g_ax_reg <= ACC_W'(f_xl_reg) + (ACC_W'(f_xh_reg) << 16);
            g_ay_reg <= ACC_W'(f_yl_reg) + (ACC_W'(f_yh_reg) << 16);
        end
    end

    // ---------------- stage H: round drag term, apply ----------------
    logic [ACC_W-1:0] rx_sum, ry_sum;
    logic [VD_W-1:0]  dgx, dgy;
    logic             h_vld_reg;
    logic [POS_W-1:0] h_px_reg, h_py_reg;
    logic signed [VD_W-1:0] h_vx_reg, h_vy_reg;

    always_comb
    begin
        rx_sum = g_ax_reg + (ACC_W'(1) << 31);
        ry_sum = g_ay_reg + (ACC_W'(1) << 31);
        dgx    = VD_W'(rx_sum[ACC_W-1:32]);
        dgy    = VD_W'(ry_sum[ACC_W-1:32]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_vld_reg <= 1'b0;
        else if (adv)
            h_vld_reg <= g_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            h_px_reg <= g_p_reg.px;
            h_py_reg <= g_p_reg.py;
            h_vx_reg <= VD_W'(g_p_reg.vx) + (g_nx_reg ? -dgx : dgx);
            h_vy_reg <= VD_W'(g_p_reg.vy) + (g_ny_reg ? -dgy : dgy);
        end
    end

    // ---------------- stage I: velocity * dt ----------------
    logic                 i_vld_reg;
    logic [POS_W-1:0]     i_px_reg, i_py_reg;
    logic signed [VD_W-1:0] i_vx_reg, i_vy_reg;
    logic [VD_W+DT_W-1:0] i_mx_reg, i_my_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            i_vld_reg <= 1'b0;
        else if (adv)
            i_vld_reg <= h_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            i_px_reg <= h_px_reg;
            i_py_reg <= h_py_reg;
            i_vx_reg <= h_vx_reg;
            i_vy_reg <= h_vy_reg;
            i_mx_reg <= (h_vx_reg[VD_W-1] ? VD_W'(-h_vx_reg) : VD_W'(h_vx_reg)) * dt_reg;
            i_my_reg <= (h_vy_reg[VD_W-1] ? VD_W'(-h_vy_reg) : VD_W'(h_vy_reg)) * dt_reg;
        end
    end

    // ---------------- stage J: position step and wall bounce ----------------
    logic [VD_W+DT_W-1:0]   sx_r, sy_r;
    logic [PW_W-1:0]        stx, sty;
    logic signed [PW_W-1:0] npx, npy;
    logic [POS_W-1:0]       bpx, bpy;
    logic signed [VD_W-1:0] bvx, bvy;
    logic                   j_vld_reg;
    logic [POS_W-1:0]       j_px_reg, j_py_reg;
    logic signed [VD_W-1:0] j_vx_reg, j_vy_reg;

    always_comb
    begin
        sx_r = i_mx_reg + (VD_W+DT_W)'(1 << 15);
        sy_r = i_my_reg + (VD_W+DT_W)'(1 << 15);
        stx  = PW_W'(sx_r[VD_W+DT_W-1:16]);
        sty  = PW_W'(sy_r[VD_W+DT_W-1:16]);
        npx  = $signed(PW_W'(i_px_reg)) + $signed(i_vx_reg[VD_W-1] ? -stx : stx);
        npy  = $signed(PW_W'(i_py_reg)) + $signed(i_vy_reg[VD_W-1] ? -sty : sty);
        // Clamp each axis to the field and reflect that velocity
        bvx = i_vx_reg;
        bvy = i_vy_reg;
        if (npx < 0)
        begin
            bpx = '0;
            bvx = -i_vx_reg;
        end
        else if (npx > EDGE_X)
        begin
            bpx = POS_W'(EDGE_X);
            bvx = -i_vx_reg;
        end
        else
            bpx = POS_W'(npx);
        if (npy < 0)
        begin
            bpy = '0;
            bvy = -i_vy_reg;
        end
        else if (npy > EDGE_Y)
        begin
            bpy = POS_W'(EDGE_Y);
            bvy = -i_vy_reg;
        end
        else
            bpy = POS_W'(npy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            j_vld_reg <= 1'b0;
        else if (adv)
            j_vld_reg <= i_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            j_px_reg <= bpx;
            j_py_reg <= bpy;
            j_vx_reg <= bvx;
            j_vy_reg <= bvy;
        end
    end

    // ---------------- stage K: damping multiply ----------------
    logic                  k_vld_reg;
    logic [POS_W-1:0]      k_px_reg, k_py_reg;
    logic                  k_nx_reg, k_ny_reg;
    logic [VD_W+FAC_W-1:0] k_mx_reg, k_my_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            k_vld_reg <= 1'b0;
        else if (adv)
            k_vld_reg <= j_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            k_px_reg <= j_px_reg;
            k_py_reg <= j_py_reg;
            k_nx_reg <= j_vx_reg[VD_W-1];
            k_ny_reg <= j_vy_reg[VD_W-1];
            k_mx_reg <= (j_vx_reg[VD_W-1] ? VD_W'(-j_vx_reg) : VD_W'(j_vx_reg)) * fac_reg;
            k_my_reg <= (j_vy_reg[VD_W-1] ? VD_W'(-j_vy_reg) : VD_W'(j_vy_reg)) * fac_reg;
        end
    end

    // ---------------- stage L: round, saturate, output register ----------
    logic [VD_W+FAC_W-1:0] dx_r, dy_r;
    logic [VD_W:0]         dmx, dmy;
    logic [VEL_W-1:0]      smx, smy;
    logic [POS_W-1:0]      l_px_reg, l_py_reg;
    logic [VEL_W-1:0]      l_vx_reg, l_vy_reg;

    always_comb
    begin
        dx_r = k_mx_reg + (VD_W+FAC_W)'(1 << 23);
        dy_r = k_my_reg + (VD_W+FAC_W)'(1 << 23);
        dmx  = dx_r[VD_W+FAC_W-1:24];
        dmy  = dy_r[VD_W+FAC_W-1:24];
        smx  = (dmx > VLIM) ? VEL_W'(VLIM) : VEL_W'(dmx);
        smy  = (dmy > VLIM) ? VEL_W'(VLIM) : VEL_W'(dmy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            l_vld_reg <= 1'b0;
        else if (adv)
            l_vld_reg <= k_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            l_px_reg <= k_px_reg;
            l_py_reg <= k_py_reg;
            l_vx_reg <= k_nx_reg ? -smx : smx;
            l_vy_reg <= k_ny_reg ? -smy : smy;
        end
    end

    assign m_tvalid = l_vld_reg;
    assign m_tdata  = {(TDATA_W-2*POS_W-2*VEL_W)'(0),
                       l_vy_reg, l_vx_reg, l_py_reg, l_px_reg};

    // ---------------- checks ----------------
    a_fac_range: assert property (@(posedge clk) disable iff (!rst_n)
        fac_reg <= FAC_W'(1 << 24))
        else $error("damping factor above one");

    a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(l_vx_reg) <= VEL_LIMIT && $signed(l_vx_reg) >= -VEL_LIMIT &&
                      $signed(l_vy_reg) <= VEL_LIMIT && $signed(l_vy_reg) >= -VEL_LIMIT))
        else $error("output velocity out of range");

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (PW_W'(l_px_reg) <= EDGE_X && PW_W'(l_py_reg) <= EDGE_Y))
        else $error("output position outside field");

endmodule
